/* hdl/ctb_pkg.sv */
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types, widths and codes for the child table builder.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int TOP_W       = PTR_W + 1;
    localparam int IDX_W       = 12;
    localparam int LCP_W       = 12;
    localparam int SEL_W       = 2;

    localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);

    // table select codes
    localparam logic [SEL_W-1:0] SEL_ACROSS = 2'd0;
    localparam logic [SEL_W-1:0] SEL_DOWN   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_UP     = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LCP_W-1:0] lcp;
    } t_stack_entry;

    // controller to datapath
    typedef struct packed {
        logic             load_first;
        logic             load_item;
        logic             a_pop;
        logic             u_pop;
        logic             push;
        logic             emit;
        logic [SEL_W-1:0] sel;
        logic             ovf;
        logic             run_end;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ovf_hit;
        logic a_pop_ok;
        logic a_eq;
        logic u_pop_ok;
        logic down_ok;
        logic popped;
        logic emit_ok;
    } t_status;

endpackage

/* hdl/ctb_dp.sv */
// ----------------------------------------------------------------------------
// ctb_dp
// Datapath: the two index stacks, their pointers, the index counter and the
// output word register.
// ----------------------------------------------------------------------------
module ctb_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ctb_pkg::t_cmd              i_cmd,
    output ctb_pkg::t_status           o_status,
    input  logic [ctb_pkg::LCP_W-1:0]  i_lcp_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [ctb_pkg::SEL_W-1:0]  o_table_sel,
    output logic [ctb_pkg::IDX_W-1:0]  o_position,
    output logic [ctb_pkg::IDX_W-1:0]  o_entry_value,
    output logic                       o_overflow,
    output logic                       o_run_end
);
    import ctb_pkg::*;

    t_stack_entry mem_a [STACK_DEPTH];
    t_stack_entry mem_u [STACK_DEPTH];

    logic [TOP_W-1:0] r_across_top, r_updown_top;
    logic [TOP_W-1:0] r_at, r_ut, n_at, n_ut;
    logic [TOP_W-1:0] n_at_m1, n_ut_m1;
    logic [IDX_W-1:0] r_idx_cnt;
    logic [IDX_W-1:0] r_cur_idx;
    logic [LCP_W-1:0] r_lcp;
    t_stack_entry     r_a_rdata, r_u_rdata, r_gone;
    logic [IDX_W-1:0] r_last_idx;
    logic             r_popped;
    logic             r_out_valid;
    logic             wr_en;
    logic [PTR_W-1:0] wr_a_addr, wr_u_addr;
    t_stack_entry     wr_data;
    logic [SEL_W-1:0] n_sel;
    logic [IDX_W-1:0] n_pos, n_val;

    // pointers track the working top; reads always follow the new top
    always_comb begin
        n_at = r_at;
        n_ut = r_ut;
        if (i_cmd.load_item) begin
            n_at = r_across_top;
            n_ut = r_updown_top;
        end else begin
            if (i_cmd.a_pop) n_at = r_at - 1'b1;
            if (i_cmd.u_pop) n_ut = r_ut - 1'b1;
        end
        n_at_m1 = n_at - 1'b1;
        n_ut_m1 = n_ut - 1'b1;
    end

    always_comb begin
        wr_en     = i_cmd.load_first | i_cmd.push;
        wr_a_addr = i_cmd.push ? r_at[PTR_W-1:0] : '0;
        wr_u_addr = i_cmd.push ? r_ut[PTR_W-1:0] : '0;
        wr_data   = i_cmd.push ? t_stack_entry'{idx: r_cur_idx, lcp: r_lcp}
                               : t_stack_entry'{idx: '0, lcp: i_lcp_value};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[wr_a_addr] <= wr_data;
            mem_u[wr_u_addr] <= wr_data;
        end
        r_a_rdata <= mem_a[n_at_m1[PTR_W-1:0]];
        r_u_rdata <= mem_u[n_ut_m1[PTR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across_top <= '0;
            r_updown_top <= '0;
            r_idx_cnt    <= '0;
            r_popped     <= 1'b0;
        end else if (i_cmd.load_first) begin
            r_across_top <= TOP_W'(1);
            r_updown_top <= TOP_W'(1);
            r_idx_cnt    <= '0;
        end else if (i_cmd.push) begin
            r_across_top <= r_at + 1'b1;
            r_updown_top <= r_ut + 1'b1;
            r_idx_cnt    <= r_cur_idx;
        end else if (i_cmd.load_item) begin
            r_popped <= 1'b0;
        end else if (i_cmd.u_pop) begin
            r_popped <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_at <= n_at;
        r_ut <= n_ut;
        if (i_cmd.load_item) begin
            r_lcp     <= i_lcp_value;
            r_cur_idx <= r_idx_cnt + 1'b1;
        end
        if (i_cmd.u_pop) begin
            r_gone     <= r_u_rdata;
            r_last_idx <= r_u_rdata.idx;
        end
    end

    always_comb begin
        o_status.ovf_hit  = ((r_at == TOP_FULL) && (r_lcp > r_a_rdata.lcp))
                          || ((r_ut == TOP_FULL) && (r_lcp >= r_u_rdata.lcp));
        o_status.a_pop_ok = (r_at != '0) && (r_lcp < r_a_rdata.lcp);
        o_status.a_eq     = (r_at != '0) && (r_lcp == r_a_rdata.lcp);
        o_status.u_pop_ok = (r_ut != '0) && (r_lcp < r_u_rdata.lcp);
        o_status.down_ok  = (r_ut != '0) && (r_lcp <= r_u_rdata.lcp)
                          && (r_u_rdata.lcp != r_gone.lcp);
        o_status.popped   = r_popped;
        o_status.emit_ok  = !r_out_valid || i_out_ready;
    end

    // output word
    always_comb begin
        n_sel = i_cmd.sel;
        n_pos = '0;
        n_val = '0;
        if (!i_cmd.ovf) begin
            unique case (i_cmd.sel)
                SEL_ACROSS: begin
                    n_pos = r_a_rdata.idx;
                    n_val = r_cur_idx;
                end
                SEL_DOWN: begin
                    n_pos = r_u_rdata.idx;
                    n_val = r_gone.idx;
                end
                SEL_UP: begin
                    n_pos = r_cur_idx;
                    n_val = r_last_idx;
                end
                default: begin
                    n_pos = '0;
                    n_val = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_table_sel   <= n_sel;
            o_position    <= n_pos;
            o_entry_value <= n_val;
            o_overflow    <= i_cmd.ovf;
            o_run_end     <= i_cmd.run_end;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/ctb_ctrl.sv */
// ----------------------------------------------------------------------------
// ctb_ctrl
// Controller: sequences the overflow check, the across pass, the up/down pass and the push.
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_first,
    output logic              o_in_ready,
    input  ctb_pkg::t_status  i_status,
    output ctb_pkg::t_cmd     o_cmd
);
    import ctb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OVF  = 3'd1;
    localparam logic [2:0] ST_AC   = 3'd2;
    localparam logic [2:0] ST_UD   = 3'd3;
    localparam logic [2:0] ST_DOWN = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SEL_ACROSS;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_first) begin
                        o_cmd.load_first = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = ST_OVF;
                    end
                end
            end
            ST_OVF: begin
                if (i_status.ovf_hit) begin
                    if (i_status.emit_ok) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.ovf     = 1'b1;
                        o_cmd.run_end = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    n_state = ST_AC;
                end
            end
            ST_AC: begin
                if (i_status.a_pop_ok) begin
                    o_cmd.a_pop = 1'b1;
                end else if (i_status.a_eq) begin
                    if (i_status.emit_ok) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.run_end = !i_status.u_pop_ok;
                        o_cmd.a_pop   = 1'b1;
                        n_state       = ST_UD;
                    end
                end else begin
                    n_state = ST_UD;
                end
            end
            ST_UD: begin
                if (i_status.u_pop_ok) begin
                    o_cmd.u_pop = 1'b1;
                    n_state     = ST_DOWN;
                end else if (i_status.popped) begin
                    if (i_status.emit_ok) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.sel     = SEL_UP;
                        o_cmd.run_end = 1'b1;
                        n_state       = ST_PUSH;
                    end
                end else begin
                    n_state = ST_PUSH;
                end
            end
            ST_DOWN: begin
                if (i_status.down_ok) begin
                    if (i_status.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = SEL_DOWN;
                        n_state    = ST_UD;
                    end
                end else begin
                    n_state = ST_UD;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/child_table_builder_top.sv */
// ----------------------------------------------------------------------------
// child_table_builder_top
// Streaming child table builder for an enhanced suffix array.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the LCP array one word per handshake on i_in_valid/o_in_ready, in
//   index order, with i_first high on index 0 and a closing LCP of zero.
//   Each accepted word yields zero or more table-write words on
//   o_out_valid/i_out_ready: table select (across, down, up), position and
//   value; o_run_end marks the last write caused by one input word. A word
//   that would overfill either 32-entry stack is dropped and yields a single
//   word with o_overflow high; no state changes.
// Sequence:
//   A first word resets both stacks to one entry. Any other word passes
//   the overflow check, the across pass, the up/down pass and the push;
//   each pop costs a registered stack read, and each up/down pop is followed
//   by a test of the new top for a down write. Pops are bounded by pushes.
// Reset:
//   Synchronous, active low; empties both stacks and zeroes the index.
// Back-pressure:
//   Results sit in one output register. While it is full and not taken the
//   controller holds at the next write it must load, and no input word is
//   accepted until that write is loaded; words causing no writes still pass.
// ----------------------------------------------------------------------------
module child_table_builder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ctb_pkg::LCP_W-1:0]  i_lcp_value,
    input  logic                       i_first,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ctb_pkg::SEL_W-1:0]  o_table_sel,
    output logic [ctb_pkg::IDX_W-1:0]  o_position,
    output logic [ctb_pkg::IDX_W-1:0]  o_entry_value,
    output logic                       o_overflow,
    output logic                       o_run_end
);
    import ctb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequence the passes over both stacks
    ctb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_first    (i_first),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // stacks, pointers and output register
    ctb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_lcp_value   (i_lcp_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_table_sel   (o_table_sel),
        .o_position    (o_position),
        .o_entry_value (o_entry_value),
        .o_overflow    (o_overflow),
        .o_run_end     (o_run_end)
    );

endmodule

/* test/child_table_builder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// child_table_builder_top_tb
// Self-checking bench for the streaming child table builder.
// ----------------------------------------------------------------------------
// A queue of LCP words is filled up front: a short directed part, then
// random LCP arrays, stack-filling ramps and plateaus and loose noise.
// A clocked driver offers the words on the input channel with random gaps.
// A clocked monitor takes the table writes with random back-pressure. An
// in-bench model of the two index stacks predicts every write at the moment
// its LCP word is accepted, and each write that comes out is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module child_table_builder_top_tb;

    import ctb_pkg::*;

    localparam int MAX_LEN     = 4096;
    localparam int RAND_WORDS  = 300;
    localparam int IDLE_PCT    = 22;
    // receiver hold-off: starts once this many words are in, lasts this long
    localparam int HOLD_AT     = 150;
    localparam int HOLD_LEN    = 600;
    // no idling on either side while the accepted count sits in this window
    localparam int CALM_LO     = 220;
    localparam int CALM_HI     = 300;
    // idle tail after the last predicted write, for a late stray write to show
    localparam int TAIL_CYCLES = 250;
    localparam int CYCLE_LIMIT = 1000000;

    // one LCP word waiting to be offered; drain holds it back until every
    // predicted write has come out
    typedef struct {
        logic [LCP_W-1:0] lcp;
        logic             first_flag;
        bit               drain;
    } t_lcp_word;

    // one table write as seen on the output channel
    typedef struct {
        logic [SEL_W-1:0] sel;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] val;
        logic             ovf;
        logic             run_end;
    } t_table_write;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             in_valid      = 1'b0;
    logic [LCP_W-1:0] in_lcp        = '0;
    logic             in_first      = 1'b0;
    logic             out_ready     = 1'b0;

    logic             o_in_ready;
    logic             o_out_valid;
    logic [SEL_W-1:0] o_table_sel;
    logic [IDX_W-1:0] o_position;
    logic [IDX_W-1:0] o_entry_value;
    logic             o_overflow;
    logic             o_run_end;

    t_lcp_word        lcp_words_q[$];
    t_table_write     writes_due_q[$];

    // shadow of the block's stacks and index
    t_stack_entry     across_stk[STACK_DEPTH];
    t_stack_entry     updown_stk[STACK_DEPTH];
    int               across_cnt    = 0;
    int               updown_cnt    = 0;
    int               index_now     = 0;

    int               accepted_cnt  = 0;
    int               hold_left     = 0;
    bit               hold_done     = 1'b0;
    int               cycle_cnt     = 0;
    int               fault_cnt     = 0;
    logic             calm;

    assign calm = (accepted_cnt >= CALM_LO) && (accepted_cnt < CALM_HI);

    child_table_builder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_lcp_value   (in_lcp),
        .i_first       (in_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_table_sel   (o_table_sel),
        .o_position    (o_position),
        .o_entry_value (o_entry_value),
        .o_overflow    (o_overflow),
        .o_run_end     (o_run_end)
    );

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("child_table_builder_top: mismatch");
            $finish;
        end
    end

    // Count a fault and print one line for it.
    task automatic report_fault(input string msg);
        fault_cnt++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic queue_word(input logic [LCP_W-1:0] lcp, input logic first_flag,
                              input bit drain);
        lcp_words_q.push_back(t_lcp_word'{lcp, first_flag, drain});
    endtask

    // ------------------------------------------------------------------------
    // Child table writes caused by one accepted LCP word.
    // Order: across write, down writes in pop order, then one up write naming
    // the last index popped. An overfull stack drops the word and yields a
    // single overflow write with no state change.
    // ------------------------------------------------------------------------
    task automatic predict_table_writes(input logic [LCP_W-1:0] lcp,
                                        input logic first_flag);
        t_table_write     found[$];
        t_stack_entry     gone;
        t_stack_entry     top;
        int               at;
        int               ut;
        int               nxt;
        logic [IDX_W-1:0] last_gone;
        logic             popped;

        last_gone = '0;
        popped    = 1'b0;
        if (first_flag) begin
            // restart: index 0 on both stacks, nothing written
            across_stk[0].idx = '0;
            across_stk[0].lcp = lcp;
            updown_stk[0].idx = '0;
            updown_stk[0].lcp = lcp;
            across_cnt        = 1;
            updown_cnt        = 1;
            index_now         = 0;
        end else begin
            nxt = index_now + 1;
            if (nxt >= MAX_LEN) begin
                nxt = 0;
            end

            // next-sibling pass: drop larger LCPs, link an equal one
            at = across_cnt;
            while (at > 0 && lcp < across_stk[at-1].lcp) begin
                at--;
            end
            if (at > 0 && lcp == across_stk[at-1].lcp) begin
                found.push_back(t_table_write'{SEL_ACROSS, across_stk[at-1].idx,
                                               IDX_W'(nxt), 1'b0, 1'b0});
                at--;
            end

            // up/down pass: each pop may link the new top down to the popped one
            ut = updown_cnt;
            while (ut > 0 && lcp < updown_stk[ut-1].lcp) begin
                ut--;
                gone      = updown_stk[ut];
                last_gone = gone.idx;
                popped    = 1'b1;
                if (ut > 0) begin
                    top = updown_stk[ut-1];
                    if (lcp <= top.lcp && top.lcp != gone.lcp) begin
                        found.push_back(t_table_write'{SEL_DOWN, top.idx, gone.idx,
                                                       1'b0, 1'b0});
                    end
                end
            end
            if (popped) begin
                found.push_back(t_table_write'{SEL_UP, IDX_W'(nxt), last_gone,
                                               1'b0, 1'b0});
            end

            if (at >= STACK_DEPTH || ut >= STACK_DEPTH) begin
                writes_due_q.push_back(t_table_write'{SEL_ACROSS, '0, '0, 1'b1, 1'b1});
            end else begin
                across_stk[at].idx = IDX_W'(nxt);
                across_stk[at].lcp = lcp;
                across_cnt         = at + 1;
                updown_stk[ut].idx = IDX_W'(nxt);
                updown_stk[ut].lcp = lcp;
                updown_cnt         = ut + 1;
                index_now          = nxt;
                if (found.size() > 0) begin
                    found[found.size()-1].run_end = 1'b1;
                end
                foreach (found[k]) begin
                    writes_due_q.push_back(found[k]);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the front word, hold it until taken, idle at random.
    // A drain word waits until every predicted write has come out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_table_writes(lcp_words_q[0].lcp, lcp_words_q[0].first_flag);
                void'(lcp_words_q.pop_front());
                accepted_cnt <= accepted_cnt + 1;
            end
            if (in_valid && !o_in_ready) begin
                // hold the word until the block takes it
            end else if (lcp_words_q.size() != 0
                         && (calm || $urandom_range(99) >= IDLE_PCT)
                         && !(lcp_words_q[0].drain && writes_due_q.size() != 0)) begin
                in_valid <= 1'b1;
                in_lcp   <= lcp_words_q[0].lcp;
                in_first <= lcp_words_q[0].first_flag;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take writes with random back-pressure, check each one.
    // ------------------------------------------------------------------------
    task automatic check_table_write();
        t_table_write want;

        if (writes_due_q.size() == 0) begin
            report_fault($sformatf("unexpected write sel=%0d pos=%0d val=%0d ovf=%0b end=%0b",
                                   o_table_sel, o_position, o_entry_value,
                                   o_overflow, o_run_end));
        end else begin
            want = writes_due_q.pop_front();
            if (o_table_sel !== want.sel || o_position !== want.pos
                || o_entry_value !== want.val || o_overflow !== want.ovf
                || o_run_end !== want.run_end) begin
                report_fault($sformatf({"write sel=%0d pos=%0d val=%0d ovf=%0b end=%0b,",
                                        " want sel=%0d pos=%0d val=%0d ovf=%0b end=%0b"},
                                       o_table_sel, o_position, o_entry_value,
                                       o_overflow, o_run_end, want.sel, want.pos,
                                       want.val, want.ovf, want.run_end));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                check_table_write();
            end
            out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int start_cnt;
        int seq_cnt;
        int kind;
        int len;
        int span;
        int v;
        int base;
        bit drain;

        // No first word yet: stacks start empty, index runs from 1.
        // The closing zero pops both entries; the bottom pop leaves updown empty.
        queue_word(12'd5, 1'b0, 1'b0);
        queue_word(12'hFFF, 1'b0, 1'b0);
        queue_word(12'd0, 1'b0, 1'b0);
        // Equal LCPs give across writes; a fall gives down writes and an up.
        queue_word(12'd0, 1'b1, 1'b1);
        queue_word(12'd2, 1'b0, 1'b0);
        queue_word(12'd2, 1'b0, 1'b0);
        queue_word(12'd1, 1'b0, 1'b0);
        queue_word(12'd3, 1'b0, 1'b0);
        queue_word(12'd1, 1'b0, 1'b0);
        queue_word(12'd0, 1'b0, 1'b0);
        // Top LCP then zero: one pop empties the updown stack.
        queue_word(12'hFFF, 1'b1, 1'b0);
        queue_word(12'd0, 1'b0, 1'b0);
        // Back-to-back restarts, then alternating bit patterns.
        queue_word(12'd7, 1'b1, 1'b0);
        queue_word(12'hAAA, 1'b1, 1'b0);
        queue_word(12'h555, 1'b0, 1'b0);
        queue_word(12'h555, 1'b0, 1'b0);
        queue_word(12'hFFF, 1'b0, 1'b0);
        queue_word(12'hAAA, 1'b0, 1'b0);
        queue_word(12'd0, 1'b0, 1'b0);
        queue_word(12'd0, 1'b0, 1'b0);

        // Random part, mostly whole LCP arrays with random content.
        start_cnt = lcp_words_q.size();
        seq_cnt   = 0;
        while (lcp_words_q.size() - start_cnt < RAND_WORDS) begin
            seq_cnt++;
            // every sixth sequence starts only once the block has gone quiet
            drain = (seq_cnt % 6 == 0);
            kind  = $urandom_range(99);
            if (kind < 60) begin
                // LCP array: random walk in a narrow or full span, zero sentinel
                case ($urandom_range(2))
                    0:       span = 3;
                    1:       span = 15;
                    default: span = MAX_LEN - 1;
                endcase
                v = ($urandom_range(1) == 0) ? 0 : $urandom_range(span);
                queue_word(LCP_W'(v), 1'b1, drain);
                len = $urandom_range(24, 1);
                repeat (len) begin
                    case ($urandom_range(2))
                        0:       v = v;
                        1:       v = $urandom_range(span);
                        default: v = v + $urandom_range(4) - 2;
                    endcase
                    if (v < 0) begin
                        v = 0;
                    end
                    if (v > span) begin
                        v = span;
                    end
                    queue_word(LCP_W'(v), 1'b0, 1'b0);
                end
                queue_word(12'd0, 1'b0, 1'b0);
            end else if (kind < 70) begin
                // strict ramp: fills the across stack and overflows it
                base = $urandom_range(MAX_LEN - 40);
                queue_word(LCP_W'(base), 1'b1, drain);
                len = 32 + $urandom_range(3);
                for (int k = 1; k <= len; k++) begin
                    queue_word(LCP_W'(base + k), 1'b0, 1'b0);
                end
                queue_word(12'd0, 1'b0, 1'b0);
            end else if (kind < 77) begin
                // plateau: equal LCPs fill the updown stack and overflow it
                v    = $urandom_range(MAX_LEN - 1, 1);
                base = $urandom_range(v);
                queue_word(LCP_W'(base), 1'b1, drain);
                len = 32 + $urandom_range(3);
                repeat (len) begin
                    queue_word(LCP_W'(v), 1'b0, 1'b0);
                end
                queue_word(12'd0, 1'b0, 1'b0);
            end else begin
                // loose noise over the full field range
                len = $urandom_range(4, 1);
                repeat (len) begin
                    queue_word(LCP_W'($urandom), ($urandom_range(9) == 0), 1'b0);
                end
            end
        end

        // Wait for all words in and all writes out, then let any stray
        // late write show itself.
        while (lcp_words_q.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (writes_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_cnt == 0) begin
            $display("child_table_builder_top: match");
        end else begin
            $display("child_table_builder_top: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/ctb_pkg.sv
hdl/ctb_dp.sv
hdl/ctb_ctrl.sv
hdl/child_table_builder_top.sv
test/child_table_builder_top_tb.sv
